// ----- hdl/ippc_pkg.sv -----
// shared constants, types and modular helpers for the permutation count unit
package ippc_pkg;

  // field widths
  localparam int LEN_W  = 11;
  localparam int DATA_W = 30;

  // default table limits
  localparam int DEF_MAX_N = 1024;
  localparam int DEF_MAX_K = 1024;

  // prime modulus
  localparam logic [DATA_W:0] PRIME_MOD = (DATA_W+1)'(1000000007);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INIT,
    ST_RUN,
    ST_GAP
  } ippc_state_t;

  // (a + b) mod p for a, b below p
  function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    logic [DATA_W:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - PRIME_MOD;
    return (s >= PRIME_MOD) ? d[DATA_W-1:0] : s[DATA_W-1:0];
  endfunction

  // (a - b) mod p for a, b below p
  function automatic logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] d;
    logic [DATA_W:0] w;
    d = {1'b0, a} - {1'b0, b};
    w = {1'b0, a} + PRIME_MOD - {1'b0, b};
    return (a >= b) ? d[DATA_W-1:0] : w[DATA_W-1:0];
  endfunction

endpackage

// ----- hdl/ippc_ram.sv -----
// generic single write port, single read port ram with registered read
module ippc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2050
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/inverse_pair_permutation_count_unit.sv -----
// top level: permutations of n elements with exactly k inversions, modulo 1000000007
//
// A query (in_perm_length = n, in_inversion_target = k) is taken when start is
// high and busy is low. The answer appears on out_perm_count for exactly one
// cycle with out_valid high; it cannot be held off, so capture it then. Queries
// answered without the table (k above n(n-1)/2, n of 0 or 1, or n above MAX_N
// or k above MAX_K) are settled in ST_CHECK. Otherwise the unit fills row 1 and
// then builds rows 2..n of the table, one column per cycle, in two row banks kept
// in a pair of mirrored rams: one read port fetches the previous row at j, the
// other at j-i. Each row ends with a drain state (ST_GAP) that writes back its
// last column. The rams need no clearing after reset; busy drops in the cycle
// the answer is shown.
module inverse_pair_permutation_count_unit #(
  parameter int MAX_N = ippc_pkg::DEF_MAX_N,
  parameter int MAX_K = ippc_pkg::DEF_MAX_K
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ippc_pkg::LEN_W-1:0]  in_perm_length,
  input  logic [ippc_pkg::LEN_W-1:0]  in_inversion_target,
  output logic                        out_valid,
  output logic [ippc_pkg::DATA_W-1:0] out_perm_count
);

  import ippc_pkg::*;

  localparam int ROW_LEN  = MAX_K + 1;
  localparam int RAM_DEP  = 2 * ROW_LEN;
  localparam int AW       = $clog2(RAM_DEP);
  localparam int PROD_W   = 2 * LEN_W;

  ippc_state_t state_r, state_nxt;

  // query and loop registers
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic [LEN_W-1:0]  row_r, row_nxt;
  logic [LEN_W-1:0]  col_r, col_nxt;
  logic [DATA_W-1:0] left_r, left_nxt;

  // column in flight between read and write-back
  logic              pv_r, pv_nxt;
  logic [LEN_W-1:0]  pcol_r, pcol_nxt;
  logic              psub_r, psub_nxt;

  // result word
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_count_r, out_count_nxt;

  // ram ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [DATA_W-1:0] rd_data_a;
  logic [DATA_W-1:0] rd_data_b;

  // quick-answer decode
  logic [LEN_W-1:0]  n_m1;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] max_inv;
  logic              k_too_big;
  logic              trivial_n;
  logic              out_of_range;

  // recurrence datapath
  logic [DATA_W-1:0] left_eff;
  logic [DATA_W-1:0] sum_v;
  logic [DATA_W-1:0] new_v;
  logic              cur_bank;
  logic [AW-1:0]     cur_base;
  logic [AW-1:0]     prv_base;
  logic [LEN_W-1:0]  col_diff;
  logic              col_sub;
  logic              row_last;
  logic              col_last;

  // previous row at j
  ippc_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEP)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  // mirror copy, previous row at j-i
  ippc_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEP)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  // max inversions n(n-1)/2 and early-answer conditions
  always_comb begin
    n_m1         = (n_r == '0) ? '0 : n_r - LEN_W'(1);
    prod         = PROD_W'(n_r) * PROD_W'(n_m1);
    max_inv      = prod >> 1;
    k_too_big    = PROD_W'(k_r) > max_inv;
    trivial_n    = (n_r <= LEN_W'(1));
    out_of_range = (n_r > MAX_N) || (k_r > MAX_K);
  end

  // bank bases and read addresses
  always_comb begin
    cur_bank  = row_r[0];
    cur_base  = cur_bank ? AW'(ROW_LEN) : '0;
    prv_base  = cur_bank ? '0 : AW'(ROW_LEN);
    col_sub   = (col_r >= row_r);
    col_diff  = col_r - row_r;
    rd_addr_a = prv_base + AW'(col_r);
    rd_addr_b = col_sub ? (prv_base + AW'(col_diff)) : prv_base;
    row_last  = (row_r == n_r);
    col_last  = (col_r == k_r);
  end

  // recurrence: left + prev[j] - prev[j-i]
  always_comb begin
    left_eff = (pcol_r == '0) ? '0 : left_r;
    sum_v    = mod_add(left_eff, rd_data_a);
    new_v    = psub_r ? mod_sub(sum_v, rd_data_b) : sum_v;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (k_too_big || trivial_n || out_of_range) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (col_last) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (col_last) begin
          state_nxt = ST_GAP;
        end
      end
      ST_GAP: begin
        state_nxt = row_last ? ST_IDLE : ST_RUN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt         = n_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    left_nxt      = left_r;
    pv_nxt        = 1'b0;
    pcol_nxt      = col_r;
    psub_nxt      = col_sub;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    wr_en         = 1'b0;
    wr_addr       = cur_base + AW'(pcol_r);
    wr_data       = new_v;

    // write-back of the column read last cycle
    if (pv_r) begin
      wr_en    = 1'b1;
      left_nxt = new_v;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt = in_perm_length;
          k_nxt = in_inversion_target;
        end
      end
      ST_CHECK: begin
        col_nxt = '0;
        if (k_too_big) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = '0;
        end else if (trivial_n) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = (k_r == '0) ? DATA_W'(1) : '0;
        end else if (out_of_range) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = '0;
        end
      end
      ST_INIT: begin
        // row 1 into bank 1: one at column 0, zeros after
        wr_en   = 1'b1;
        wr_addr = AW'(ROW_LEN) + AW'(col_r);
        wr_data = (col_r == '0) ? DATA_W'(1) : '0;
        if (col_last) begin
          col_nxt = '0;
          row_nxt = LEN_W'(2);
        end else begin
          col_nxt = col_r + LEN_W'(1);
        end
      end
      ST_RUN: begin
        pv_nxt = 1'b1;
        if (!col_last) begin
          col_nxt = col_r + LEN_W'(1);
        end
      end
      ST_GAP: begin
        col_nxt = '0;
        if (row_last) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = new_v;
        end else begin
          row_nxt = row_r + LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      left_r      <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      left_r      <= left_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    pcol_r      <= pcol_nxt;
    psub_r      <= psub_nxt;
    out_count_r <= out_count_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_perm_count = out_count_r;

endmodule
